FILE: rtl/dasr_pkg.sv
// shared types and constants for the dual-axis stepper ramp and homing generator
package dasr_pkg;

    // request kinds carried in the input tuser
    typedef enum logic [2:0] {
        REQ_TICK       = 3'd0,
        REQ_SET_TARGET = 3'd1,
        REQ_SEEK_HOME  = 3'd2,
        REQ_REZERO     = 3'd3,
        REQ_ESTOP      = 3'd4
    } req_type_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_INTERVAL     = 3'd0,
        CFG_START_INTERVAL   = 3'd1,
        CFG_ACCEL_DECREMENT  = 3'd2,
        CFG_HOMING_INTERVAL  = 3'd3,
        CFG_HOMING_COUNT     = 3'd4,
        CFG_MAX_TRAVEL       = 3'd5,
        CFG_FORWARD_DIR      = 3'd6
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int POS_W       = 17;
    localparam int TABLE_DEPTH = 256;

    localparam logic [15:0] RST_MIN_INTERVAL    = 16'd800;
    localparam logic [15:0] RST_START_INTERVAL  = 16'd2000;
    localparam logic [15:0] RST_ACCEL_DECREMENT = 16'd5;
    localparam logic [15:0] RST_HOMING_INTERVAL = 16'd3000;
    localparam logic [15:0] RST_HOMING_COUNT    = 16'd41664;
    localparam logic [7:0]  RST_MAX_TRAVEL      = 8'd100;
    localparam logic [1:0]  RST_FORWARD_DIR     = 2'b11;
    localparam logic [7:0]  MM_UNHOMED          = 8'hFF;

    typedef struct packed {
        logic [15:0] min_interval;
        logic [15:0] start_interval;
        logic [15:0] accel_decrement;
        logic [15:0] homing_interval;
        logic [15:0] homing_count;
        logic [7:0]  max_travel;
        logic [1:0]  forward_dir;
    } cfg_t;

    // decoded command for one axis, valid with the transfer strobe
    typedef struct packed {
        logic        tick;
        logic        run;
        logic        set_target;
        logic        seek_home;
        logic        rezero;
        logic        estop_on;
        logic [15:0] target_steps;
    } axis_cmd_t;

    // axis view after the item is applied
    typedef struct packed {
        logic       step;
        logic       dir;
        logic       enable;
        logic [7:0] report_mm;
        logic       busy;
    } axis_status_t;

endpackage

FILE: rtl/dual_axis_stepper_ramp_homing.sv
// top level: request decode, stop latch, target table and result register
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+----------------------------------------
//  request   | in  | s_axis_tvalid/tready      | tuser: req_type, axis; tdata: target_mm, stop_on
//  result    | out | m_axis_tvalid/tready      | tdata: steps, dirs, enables, mm, pending
//  config    | in  | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
//  one request per cycle while no result is stalled, each giving one result in the cycle after its transfer
//  axis timing and millimetre tracking are updated in the same cycle as the transfer
//  the result register accepts a new request while its held result is being taken
//  a stalled result holds the request side: tready falls only while m_axis_tready is low
//  aresetn (synchronous) restores register defaults and idle, unhomed axes
module dual_axis_stepper_ramp_homing #(
    parameter int unsigned AXES                = 2,
    parameter int unsigned STEPS_PER_MM_TENTHS = 3968
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // target_mm[7:0], stop_on[8], zero
    input  logic [3:0]                        s_axis_tuser,  // req_type[2:0], axis[3]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // step_axis0[0], step_axis1[1], dir_axis0[2], dir_axis1[3], enable_axis0[4],
    // enable_axis1[5], report_mm_axis0[13:6], report_mm_axis1[21:14], any_moving[22],
    // pending_axis0[23], pending_axis1[24], zero
    output logic [31:0]                       m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dasr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dasr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NUM_AXES = 2;

    dasr_pkg::cfg_t          cfg;
    dasr_pkg::axis_cmd_t     axis_cmd [NUM_AXES];
    dasr_pkg::axis_status_t  axis_stat [NUM_AXES];

    logic [2:0]  req_type;
    logic        req_axis;
    logic [7:0]  target_mm;
    logic        stop_on;
    logic        s_fire;
    logic        is_tick;
    logic        is_set;
    logic        is_seek;
    logic        is_rezero;
    logic        is_estop;
    logic [7:0]  mm_clamped;
    logic [15:0] tgt_rom [dasr_pkg::TABLE_DEPTH];
    logic [15:0] tgt_steps;
    logic        stop_reg, stop_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;
    logic [1:0]  pend;

    assign req_type  = s_axis_tuser[2:0];
    assign req_axis  = s_axis_tuser[3];
    assign target_mm = s_axis_tdata[7:0];
    assign stop_on   = s_axis_tdata[8];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    dasr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb begin
        is_tick   = 1'b0;
        is_set    = 1'b0;
        is_seek   = 1'b0;
        is_rezero = 1'b0;
        is_estop  = 1'b0;
        case (req_type)
            dasr_pkg::REQ_TICK:       is_tick   = 1'b1;
            dasr_pkg::REQ_SET_TARGET: is_set    = 1'b1;
            dasr_pkg::REQ_SEEK_HOME:  is_seek   = 1'b1;
            dasr_pkg::REQ_REZERO:     is_rezero = 1'b1;
            dasr_pkg::REQ_ESTOP:      is_estop  = 1'b1;
            default: ;
        endcase
    end

    // millimetre to step table, built at elaboration, saturating at 16 bits
    for (genvar i = 0; i < dasr_pkg::TABLE_DEPTH; i++) begin : g_tgt_rom
        localparam int unsigned TGT_RAW = (i * STEPS_PER_MM_TENTHS) / 10;
        assign tgt_rom[i] = (TGT_RAW > 32'd65535) ? 16'hFFFF : TGT_RAW[15:0];
    end

    assign mm_clamped = (target_mm > cfg.max_travel) ? cfg.max_travel : target_mm;
    assign tgt_steps  = tgt_rom[mm_clamped];

    assign stop_next = (s_fire && is_estop) ? stop_on : stop_reg;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        if (a < AXES) begin : g_live
            always_comb begin
                axis_cmd[a].tick         = is_tick;
                axis_cmd[a].run          = is_tick && !stop_reg;
                axis_cmd[a].set_target   = is_set && (req_axis == 1'(a));
                axis_cmd[a].seek_home    = is_seek && (req_axis == 1'(a));
                axis_cmd[a].rezero       = is_rezero && (req_axis == 1'(a));
                axis_cmd[a].estop_on     = is_estop && stop_on;
                axis_cmd[a].target_steps = tgt_steps;
            end

            dasr_axis #(
                .STEPS_PER_MM_TENTHS (STEPS_PER_MM_TENTHS)
            ) u_axis (
                .aclk    (aclk),
                .aresetn (aresetn),
                .advance (s_fire),
                .cmd     (axis_cmd[a]),
                .cfg     (cfg),
                .fwd_dir (cfg.forward_dir[a]),
                .status  (axis_stat[a])
            );
        end else begin : g_absent
            // axis not built: reports the idle reset state
            assign axis_cmd[a]  = '0;
            assign axis_stat[a] = '{step: 1'b0, dir: 1'b0, enable: 1'b0,
                                    report_mm: dasr_pkg::MM_UNHOMED, busy: 1'b0};
        end
    end

    assign pend[0] = axis_stat[0].busy && !stop_next;
    assign pend[1] = axis_stat[1].busy && !stop_next;

    always_comb begin
        m_data_next        = 32'd0;
        m_data_next[0]     = axis_stat[0].step;
        m_data_next[1]     = axis_stat[1].step;
        m_data_next[2]     = axis_stat[0].dir;
        m_data_next[3]     = axis_stat[1].dir;
        m_data_next[4]     = axis_stat[0].enable;
        m_data_next[5]     = axis_stat[1].enable;
        m_data_next[13:6]  = axis_stat[0].report_mm;
        m_data_next[21:14] = axis_stat[1].report_mm;
        m_data_next[22]    = |pend;
        m_data_next[23]    = pend[0];
        m_data_next[24]    = pend[1];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            stop_reg    <= stop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while result is stalled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("transfer produced no result");

    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && stop_next) |=>
            (!m_data_reg[4] && !m_data_reg[5] && !m_data_reg[22]))
        else $error("drivers or motion reported during emergency stop");

    a_stop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && is_estop) |=> (stop_reg == $past(stop_reg)))
        else $error("stop latch changed without a stop request");

endmodule

FILE: rtl/dasr_cfg.sv
// configuration register file for the stepper generator
module dasr_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dasr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dasr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dasr_pkg::cfg_t                    cfg
);

    dasr_pkg::cfg_t cfg_reg;
    dasr_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dasr_pkg::CFG_MIN_INTERVAL:    cfg_next.min_interval    = cfg_data;
                dasr_pkg::CFG_START_INTERVAL:  cfg_next.start_interval  = cfg_data;
                dasr_pkg::CFG_ACCEL_DECREMENT: cfg_next.accel_decrement = cfg_data;
                dasr_pkg::CFG_HOMING_INTERVAL: cfg_next.homing_interval = cfg_data;
                dasr_pkg::CFG_HOMING_COUNT:    cfg_next.homing_count    = cfg_data;
                dasr_pkg::CFG_MAX_TRAVEL:      cfg_next.max_travel      = cfg_data[7:0];
                dasr_pkg::CFG_FORWARD_DIR:     cfg_next.forward_dir     = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_interval    <= dasr_pkg::RST_MIN_INTERVAL;
            cfg_reg.start_interval  <= dasr_pkg::RST_START_INTERVAL;
            cfg_reg.accel_decrement <= dasr_pkg::RST_ACCEL_DECREMENT;
            cfg_reg.homing_interval <= dasr_pkg::RST_HOMING_INTERVAL;
            cfg_reg.homing_count    <= dasr_pkg::RST_HOMING_COUNT;
            cfg_reg.max_travel      <= dasr_pkg::RST_MAX_TRAVEL;
            cfg_reg.forward_dir     <= dasr_pkg::RST_FORWARD_DIR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/dasr_axis.sv
// per-axis step timing, interval ramp, homing and millimetre tracking
module dasr_axis #(
    parameter int unsigned STEPS_PER_MM_TENTHS = 3968
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  dasr_pkg::axis_cmd_t     cmd,
    input  dasr_pkg::cfg_t          cfg,
    input  logic                    fwd_dir,
    output dasr_pkg::axis_status_t  status
);

    // millimetre tracking: pos*10 = quot*DIV + rem, with 0 <= rem < DIV
    localparam int REM_W = $clog2(STEPS_PER_MM_TENTHS + 10);
    localparam logic [REM_W-1:0] DIV_R = REM_W'(STEPS_PER_MM_TENTHS);
    localparam logic [REM_W-1:0] TEN_R = REM_W'(10);
    localparam logic signed [dasr_pkg::POS_W-1:0] POS_FLOOR =
        {1'b1, {(dasr_pkg::POS_W-1){1'b0}}};

    logic signed [dasr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic signed [dasr_pkg::POS_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0]                  rem_reg, rem_next;
    logic [15:0]                       tgt_reg, tgt_next;
    logic [15:0]                       elapsed_reg, elapsed_next;
    logic [15:0]                       interval_reg, interval_next;
    logic [15:0]                       homing_left_reg, homing_left_next;
    logic                              enable_reg, enable_next;
    logic                              homed_reg, homed_next;
    logic                              dir_reg, dir_next;

    logic [15:0]                       el_inc;
    logic signed [dasr_pkg::POS_W-1:0] tgt_ext;
    logic signed [dasr_pkg::POS_W-1:0] tgt_ext_next;
    logic signed [dasr_pkg::POS_W-1:0] max_ext;
    logic [16:0]                       ramp_floor;
    logic [REM_W-1:0]                  rem_up;
    logic                              step;
    logic                              do_move;
    logic                              move_up;
    logic                              clear_pos;

    assign el_inc     = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 16'd1;
    assign tgt_ext    = signed'({1'b0, tgt_reg});
    assign ramp_floor = {1'b0, cfg.min_interval} + {1'b0, cfg.accel_decrement};
    assign rem_up     = rem_reg + TEN_R;

    always_comb begin
        pos_next         = pos_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;
        tgt_next         = tgt_reg;
        elapsed_next     = elapsed_reg;
        interval_next    = interval_reg;
        homing_left_next = homing_left_reg;
        enable_next      = enable_reg;
        homed_next       = homed_reg;
        dir_next         = dir_reg;
        step             = 1'b0;
        do_move          = 1'b0;
        move_up          = 1'b0;
        clear_pos        = 1'b0;

        if (advance) begin
            if (cmd.tick) begin
                elapsed_next = el_inc;
                if (!cmd.run) begin
                    enable_next = 1'b0;
                end else if (homing_left_reg != 16'd0) begin
                    if (el_inc >= cfg.homing_interval) begin
                        elapsed_next     = 16'd0;
                        enable_next      = 1'b1;
                        step             = 1'b1;
                        do_move          = 1'b1;
                        homing_left_next = homing_left_reg - 16'd1;
                        // last homing step: this spot becomes zero
                        if (homing_left_reg == 16'd1) begin
                            clear_pos   = 1'b1;
                            homed_next  = 1'b1;
                            enable_next = 1'b0;
                        end
                    end
                end else if (pos_reg == tgt_ext) begin
                    enable_next   = 1'b0;
                    interval_next = cfg.start_interval;
                end else if (el_inc >= interval_reg) begin
                    elapsed_next = 16'd0;
                    enable_next  = 1'b1;
                    step         = 1'b1;
                    do_move      = 1'b1;
                    move_up      = (pos_reg < tgt_ext);
                    if (interval_reg > cfg.min_interval) begin
                        if ({1'b0, interval_reg} > ramp_floor) begin
                            interval_next = interval_reg - cfg.accel_decrement;
                        end else begin
                            interval_next = cfg.min_interval;
                        end
                    end
                end
            end
            if (cmd.set_target) begin
                tgt_next = cmd.target_steps;
            end
            if (cmd.seek_home) begin
                homed_next       = 1'b0;
                homing_left_next = cfg.homing_count;
            end
            if (cmd.rezero) begin
                homing_left_next = 16'd0;
                homed_next       = 1'b1;
                clear_pos        = 1'b1;
            end
            if (cmd.estop_on) begin
                homing_left_next = 16'd0;
                enable_next      = 1'b0;
            end
        end

        if (do_move) begin
            dir_next = move_up ? fwd_dir : ~fwd_dir;
            if (move_up) begin
                pos_next = pos_reg + 17'sd1;
                if (rem_up >= DIV_R) begin
                    rem_next  = rem_up - DIV_R;
                    quot_next = quot_reg + 17'sd1;
                end else begin
                    rem_next = rem_up;
                end
            end else if (pos_reg != POS_FLOOR) begin
                pos_next = pos_reg - 17'sd1;
                if (rem_reg < TEN_R) begin
                    rem_next  = rem_reg + DIV_R - TEN_R;
                    quot_next = quot_reg - 17'sd1;
                end else begin
                    rem_next = rem_reg - TEN_R;
                end
            end
        end

        if (clear_pos) begin
            pos_next  = '0;
            quot_next = '0;
            rem_next  = '0;
            tgt_next  = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            quot_reg        <= '0;
            rem_reg         <= '0;
            tgt_reg         <= 16'd0;
            elapsed_reg     <= 16'hFFFF;
            interval_reg    <= dasr_pkg::RST_START_INTERVAL;
            homing_left_reg <= 16'd0;
            enable_reg      <= 1'b0;
            homed_reg       <= 1'b0;
            dir_reg         <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            quot_reg        <= quot_next;
            rem_reg         <= rem_next;
            tgt_reg         <= tgt_next;
            elapsed_reg     <= elapsed_next;
            interval_reg    <= interval_next;
            homing_left_reg <= homing_left_next;
            enable_reg      <= enable_next;
            homed_reg       <= homed_next;
            dir_reg         <= dir_next;
        end
    end

    // status after the item, fed straight into the result register
    assign tgt_ext_next = signed'({1'b0, tgt_next});
    assign max_ext      = signed'({{(dasr_pkg::POS_W-8){1'b0}}, cfg.max_travel});

    always_comb begin
        status.step   = step;
        status.dir    = dir_next;
        status.enable = enable_next;
        status.busy   = (homing_left_next != 16'd0) || (pos_next != tgt_ext_next);
        if (!homed_next) begin
            status.report_mm = dasr_pkg::MM_UNHOMED;
        end else if (quot_next <= 17'sd0) begin
            status.report_mm = 8'd0;
        end else if (quot_next > max_ext) begin
            status.report_mm = cfg.max_travel;
        end else begin
            status.report_mm = quot_next[7:0];
        end
    end

    a_homing_unhomed: assert property (@(posedge aclk) disable iff (!aresetn)
        (homing_left_reg != 16'd0) |-> !homed_reg)
        else $error("axis homing while marked homed");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < DIV_R)
        else $error("millimetre remainder out of range");

endmodule

FILE: verif/dasr_motion_checker.sv
// result checker for the dual-axis stepper: tracks both axes and compares every result transfer
module dasr_motion_checker #(
    parameter int STEPS_PER_MM_TENTHS = 3968
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // target_mm[7:0], stop_on[8]
    input  logic [3:0]                          s_axis_tuser,  // req_type[2:0], axis[3]
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [31:0]                         m_axis_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [dasr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dasr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  results_owed
);

    localparam int POS_FLOOR = -65536;

    typedef struct packed {
        logic [1:0] step;
        logic [1:0] dir;
        logic [1:0] enable;
        logic [7:0] mm0;
        logic [7:0] mm1;
        logic       moving;
        logic [1:0] pending;
    } motion_frame_t;

    dasr_pkg::cfg_t                    settings;
    logic signed [dasr_pkg::POS_W-1:0] pos_steps [2];
    logic [15:0]                       goal_steps [2];
    logic [15:0]                       since_step_us [2];
    logic [15:0]                       step_gap_us [2];
    logic [15:0]                       home_left [2];
    logic [1:0]                        drive_on;
    logic [1:0]                        is_homed;
    logic [1:0]                        dir_pin;
    logic                              estop_held;
    motion_frame_t                     owed_frames [$];

    initial fail_count = 0;

    task automatic note_fail(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_bits(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) note_fail($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    function automatic logic at_goal(input int a);
        return int'(pos_steps[a]) == int'({1'b0, goal_steps[a]});
    endfunction

    function automatic logic [7:0] position_mm(input int a);
        int mm;
        if (!is_homed[a]) return dasr_pkg::MM_UNHOMED;
        if (int'(pos_steps[a]) <= 0) return 8'd0;
        mm = int'(pos_steps[a]) * 10 / STEPS_PER_MM_TENTHS;
        if (mm > int'(settings.max_travel)) mm = int'(settings.max_travel);
        return mm[7:0];
    endfunction

    task automatic move_one(input int a, input logic up);
        logic fwd;
        fwd = settings.forward_dir[a];
        dir_pin[a] = up ? fwd : ~fwd;
        if (up) pos_steps[a] = pos_steps[a] + 17'sd1;
        // downward travel pins at the most negative position
        else if (int'(pos_steps[a]) > POS_FLOOR) pos_steps[a] = pos_steps[a] - 17'sd1;
    endtask

    task automatic serve_axis(input int a, output logic stepped);
        stepped = 1'b0;
        if (home_left[a] != 16'd0) begin
            if (since_step_us[a] >= settings.homing_interval) begin
                since_step_us[a] = 16'd0;
                drive_on[a] = 1'b1;
                move_one(a, 1'b0);
                home_left[a] = home_left[a] - 16'd1;
                if (home_left[a] == 16'd0) begin
                    pos_steps[a] = '0;
                    goal_steps[a] = 16'd0;
                    is_homed[a] = 1'b1;
                    drive_on[a] = 1'b0;
                end
                stepped = 1'b1;
            end
        end else if (at_goal(a)) begin
            drive_on[a] = 1'b0;
            step_gap_us[a] = settings.start_interval;
        end else if (since_step_us[a] >= step_gap_us[a]) begin
            since_step_us[a] = 16'd0;
            drive_on[a] = 1'b1;
            move_one(a, int'(pos_steps[a]) < int'({1'b0, goal_steps[a]}));
            // linear ramp down to the floor interval; a gap already at or below the floor is kept
            if (step_gap_us[a] > settings.min_interval) begin
                if (int'(step_gap_us[a]) >
                    int'(settings.min_interval) + int'(settings.accel_decrement))
                    step_gap_us[a] = step_gap_us[a] - settings.accel_decrement;
                else
                    step_gap_us[a] = settings.min_interval;
            end
            stepped = 1'b1;
        end
    endtask

    task automatic take_request(input logic [2:0] kind, input logic ax,
                                input logic [7:0] mm_req, input logic stop_req);
        logic [1:0]    stepped;
        logic          hit;
        logic [7:0]    mm_lim;
        int            goal;
        motion_frame_t f;
        stepped = 2'b00;
        case (kind)
            dasr_pkg::REQ_TICK: begin
                for (int a = 0; a < 2; a++)
                    if (since_step_us[a] != 16'hFFFF) since_step_us[a] = since_step_us[a] + 16'd1;
                if (estop_held) begin
                    drive_on = 2'b00;
                end else begin
                    for (int a = 0; a < 2; a++) begin
                        serve_axis(a, hit);
                        stepped[a] = hit;
                    end
                end
            end
            dasr_pkg::REQ_SET_TARGET: begin
                mm_lim = (mm_req > settings.max_travel) ? settings.max_travel : mm_req;
                goal = int'(mm_lim) * STEPS_PER_MM_TENTHS / 10;
                if (goal > 65535) goal = 65535;
                goal_steps[ax] = goal[15:0];
            end
            dasr_pkg::REQ_SEEK_HOME: begin
                is_homed[ax] = 1'b0;
                home_left[ax] = settings.homing_count;
            end
            dasr_pkg::REQ_REZERO: begin
                home_left[ax] = 16'd0;
                pos_steps[ax] = '0;
                goal_steps[ax] = 16'd0;
                is_homed[ax] = 1'b1;
            end
            dasr_pkg::REQ_ESTOP: begin
                estop_held = stop_req;
                if (stop_req) begin
                    home_left[0] = 16'd0;
                    home_left[1] = 16'd0;
                    drive_on = 2'b00;
                end
            end
            default: ;
        endcase
        f.step = stepped;
        f.dir = dir_pin;
        f.enable = drive_on;
        f.mm0 = position_mm(0);
        f.mm1 = position_mm(1);
        for (int a = 0; a < 2; a++)
            f.pending[a] = !estop_held && (home_left[a] != 16'd0 || !at_goal(a));
        f.moving = |f.pending;
        owed_frames.push_back(f);
    endtask

    task automatic check_result(input logic [31:0] got);
        motion_frame_t want;
        if (owed_frames.size() == 0) begin
            note_fail($sformatf("result %h with nothing expected", got));
        end else begin
            want = owed_frames.pop_front();
            check_bits("step_axis0", got[0], want.step[0]);
            check_bits("step_axis1", got[1], want.step[1]);
            check_bits("dir_axis0", got[2], want.dir[0]);
            check_bits("dir_axis1", got[3], want.dir[1]);
            check_bits("enable_axis0", got[4], want.enable[0]);
            check_bits("enable_axis1", got[5], want.enable[1]);
            check_bits("report_mm_axis0", got[13:6], want.mm0);
            check_bits("report_mm_axis1", got[21:14], want.mm1);
            check_bits("any_moving", got[22], want.moving);
            check_bits("pending_axis0", got[23], want.pending[0]);
            check_bits("pending_axis1", got[24], want.pending[1]);
            check_bits("padding", got[31:25], 8'd0);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            settings.min_interval    = dasr_pkg::RST_MIN_INTERVAL;
            settings.start_interval  = dasr_pkg::RST_START_INTERVAL;
            settings.accel_decrement = dasr_pkg::RST_ACCEL_DECREMENT;
            settings.homing_interval = dasr_pkg::RST_HOMING_INTERVAL;
            settings.homing_count    = dasr_pkg::RST_HOMING_COUNT;
            settings.max_travel      = dasr_pkg::RST_MAX_TRAVEL;
            settings.forward_dir     = dasr_pkg::RST_FORWARD_DIR;
            for (int a = 0; a < 2; a++) begin
                pos_steps[a] = '0;
                goal_steps[a] = 16'd0;
                since_step_us[a] = 16'hFFFF;
                step_gap_us[a] = dasr_pkg::RST_START_INTERVAL;
                home_left[a] = 16'd0;
            end
            drive_on = 2'b00;
            is_homed = 2'b00;
            dir_pin = 2'b00;
            estop_held = 1'b0;
            owed_frames.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dasr_pkg::CFG_MIN_INTERVAL:    settings.min_interval = cfg_data;
                    dasr_pkg::CFG_START_INTERVAL:  settings.start_interval = cfg_data;
                    dasr_pkg::CFG_ACCEL_DECREMENT: settings.accel_decrement = cfg_data;
                    dasr_pkg::CFG_HOMING_INTERVAL: settings.homing_interval = cfg_data;
                    dasr_pkg::CFG_HOMING_COUNT:    settings.homing_count = cfg_data;
                    dasr_pkg::CFG_MAX_TRAVEL:      settings.max_travel = cfg_data[7:0];
                    dasr_pkg::CFG_FORWARD_DIR:     settings.forward_dir = cfg_data[1:0];
                    default: ;
                endcase
            end
            // a result leaving now belongs to an earlier request, so compare first
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                take_request(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[7:0],
                             s_axis_tdata[8]);
        end
        results_owed <= owed_frames.size();
    end

endmodule

FILE: verif/tb_dual_axis_stepper_ramp_homing.sv
// testbench top: drives requests, settings and result back-pressure, then gives the verdict
module tb_dual_axis_stepper_ramp_homing;

    localparam int STEPS_TENTHS = 3968;
    localparam int RUN_LIMIT    = 10_000_000;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic [15:0]                      s_axis_tdata = '0;
    logic [3:0]                       s_axis_tuser = '0;
    logic                             m_axis_tready = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [dasr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dasr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             s_axis_tready;
    logic                             m_axis_tvalid;
    logic [31:0]                      m_axis_tdata;
    logic                             cfg_ready;
    int                               fail_count;
    int                               results_owed;

    int   stall_left = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dual_axis_stepper_ramp_homing #(
        .AXES(2),
        .STEPS_PER_MM_TENTHS(STEPS_TENTHS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    dasr_motion_checker #(
        .STEPS_PER_MM_TENTHS(STEPS_TENTHS)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .results_owed(results_owed)
    );

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_pause();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [2:0] kind, input logic ax,
                                input logic [7:0] mm, input logic stop_req);
        int gap;
        gap = tx_steady ? 0 : pick_pause();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {ax, kind};
        s_axis_tdata <= {7'd0, stop_req, mm};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last register
    task automatic write_reg(input dasr_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic run_phase(input logic [15:0] min_us, input logic [15:0] start_us,
                             input logic [15:0] dec_us, input logic [15:0] home_us,
                             input logic [15:0] home_cnt, input logic [7:0] travel,
                             input logic [1:0] fwd, input int items, input int cmd_pct);
        logic [2:0] kind;
        drain_results();
        write_reg(dasr_pkg::CFG_MIN_INTERVAL, min_us);
        write_reg(dasr_pkg::CFG_START_INTERVAL, start_us);
        write_reg(dasr_pkg::CFG_ACCEL_DECREMENT, dec_us);
        write_reg(dasr_pkg::CFG_HOMING_INTERVAL, home_us);
        write_reg(dasr_pkg::CFG_HOMING_COUNT, home_cnt);
        write_reg(dasr_pkg::CFG_MAX_TRAVEL, {8'd0, travel});
        write_reg(dasr_pkg::CFG_FORWARD_DIR, {14'd0, fwd});
        cfg_valid <= 1'b0;
        for (int i = 0; i < items; i++) begin
            if (i % 100 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 199) == 0) drain_results();
            // mostly ticks so that moves and homing run to completion
            if ($urandom_range(0, 99) >= cmd_pct) begin
                kind = dasr_pkg::REQ_TICK;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: kind = dasr_pkg::REQ_SET_TARGET;
                    4, 5:       kind = dasr_pkg::REQ_SEEK_HOME;
                    6, 7:       kind = dasr_pkg::REQ_REZERO;
                    8:          kind = dasr_pkg::REQ_ESTOP;
                    default:    kind = 3'(dasr_pkg::REQ_ESTOP + $urandom_range(1, 3));
                endcase
            end
            send_request(kind, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset settings
        send_request(dasr_pkg::REQ_TICK, 1'b1, 8'hFF, 1'b1);
        send_request(3'(dasr_pkg::REQ_ESTOP + 1), 1'b0, 8'h00, 1'b0);
        send_request(3'(dasr_pkg::REQ_ESTOP + 2), 1'b1, 8'h55, 1'b1);
        send_request(3'(dasr_pkg::REQ_ESTOP + 3), 1'b0, 8'hAA, 1'b0);
        send_request(dasr_pkg::REQ_SET_TARGET, 1'b0, 8'hFF, 1'b0);
        send_request(dasr_pkg::REQ_TICK, 1'b0, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_REZERO, 1'b0, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_REZERO, 1'b1, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_SET_TARGET, 1'b1, 8'd1, 1'b0);
        send_request(dasr_pkg::REQ_TICK, 1'b0, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_ESTOP, 1'b0, 8'h00, 1'b1);
        send_request(dasr_pkg::REQ_TICK, 1'b1, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_SET_TARGET, 1'b0, 8'd2, 1'b0);
        send_request(dasr_pkg::REQ_ESTOP, 1'b1, 8'hFF, 1'b0);
        send_request(dasr_pkg::REQ_TICK, 1'b0, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_SEEK_HOME, 1'b1, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_TICK, 1'b0, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_ESTOP, 1'b0, 8'h00, 1'b1);
        send_request(dasr_pkg::REQ_ESTOP, 1'b0, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_TICK, 1'b0, 8'h00, 1'b0);
        send_request(dasr_pkg::REQ_SET_TARGET, 1'b0, 8'd0, 1'b0);
        send_request(dasr_pkg::REQ_TICK, 1'b0, 8'h00, 1'b0);

        // ramp from 4 down to 1, short homing
        run_phase(16'd1, 16'd4, 16'd1, 16'd2, 16'd12, 8'd1, 2'b00, 300, 3);
        // start below the floor (no ramp), seek home without steps, long moves
        run_phase(16'd2, 16'd1, 16'd0, 16'd1, 16'd0, 8'd2, 2'b01, 700, 1);
        // zero travel clamps both targets and reports; huge decrement, endless homing
        run_phase(16'd1, 16'd8, 16'hFFFF, 16'd3, 16'hFFFF, 8'd0, 2'b10, 250, 4);
        // slowest settings
        run_phase(16'hFFFF, 16'hFFFF, 16'd5, 16'hFFFF, 16'd1, 8'd165, 2'b11, 120, 5);
        // start equal to the floor
        run_phase(16'd1, 16'd1, 16'd2, 16'd1, 16'd5, 8'd1, 2'b01, 350, 3);
        run_phase(dasr_pkg::RST_MIN_INTERVAL, dasr_pkg::RST_START_INTERVAL,
                  dasr_pkg::RST_ACCEL_DECREMENT, dasr_pkg::RST_HOMING_INTERVAL,
                  dasr_pkg::RST_HOMING_COUNT, dasr_pkg::RST_MAX_TRAVEL,
                  dasr_pkg::RST_FORWARD_DIR, 100, 5);
        run_phase(16'd2, 16'd6, 16'd3, 16'd2, 16'd20, 8'd2, 2'b11, 250, 2);

        drain_results();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: dual_axis_stepper_ramp_homing.f
rtl/dasr_pkg.sv
rtl/dasr_cfg.sv
rtl/dasr_axis.sv
rtl/dual_axis_stepper_ramp_homing.sv
verif/dasr_motion_checker.sv
verif/tb_dual_axis_stepper_ramp_homing.sv
